// ----- hdl/csp_pkg.sv -----
// ---------------------------------------------------------------------------
// csp_pkg
// Shared widths, register indexes, opcodes and helper types for the
// crop and scale pixel readout block.
// ---------------------------------------------------------------------------
package csp_pkg;

   // pixel store geometry
   localparam int STORE_PIXELS  = 65536;
   localparam int ADDR_W        = $clog2(STORE_PIXELS);
   localparam int PIXEL_W       = 32;

   // image dimensions and coordinates
   localparam int MAX_DIMENSION = 1024;
   localparam int DIM_W         = 11;
   localparam int COORD_W       = 10;
   localparam int INDEX_W       = 16;
   localparam int BYTE_W        = 8;

   // coordinate product, quotient and linear source index
   localparam int PROD_W        = COORD_W + DIM_W;
   localparam int QUO_W         = DIM_W;
   localparam int SRC_W         = 2 * DIM_W;

   // configuration port
   localparam int CSR_INDEX_W   = 4;
   localparam int CSR_DATA_W    = DIM_W;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH   = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ALPHA_PRESENT = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CROP_LEFT     = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_CROP_TOP      = 4'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_CROP_COLS     = 4'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_CROP_ROWS     = 4'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_DEST_COLS     = 4'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_DEST_ROWS     = 4'd7;

   // request opcodes
   localparam logic OP_STORE = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   // alpha byte used when the stored pixel has no alpha
   localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;

   // divider launch bundle
   typedef struct packed {
      logic               start;
      logic [PROD_W-1:0]  numerator;
      logic [DIM_W-1:0]   divisor;
   } div_req_type;

   // divider completion bundle
   typedef struct packed {
      logic               done;
      logic [QUO_W-1:0]   quotient;
   } div_rsp_type;

   // saturate a size register write at the largest dimension
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CSR_DATA_W-1:0] value);
      logic [DIM_W-1:0] result;
      if (32'(value) > MAX_DIMENSION) begin
         result = DIM_W'(MAX_DIMENSION);
      end else begin
         result = DIM_W'(value);
      end
      return result;
   endfunction

endpackage

// ----- hdl/csp_ram.sv -----
// ---------------------------------------------------------------------------
// csp_ram
// Generic single-clock RAM, one write port and one read port with the
// read data registered.
// ---------------------------------------------------------------------------
module csp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/csp_divider.sv -----
// ---------------------------------------------------------------------------
// csp_divider
// Restoring divider, one quotient bit per cycle. The caller guarantees
// that the quotient fits in QUO_W bits, so the upper numerator bits seed
// the partial remainder directly.
// ---------------------------------------------------------------------------
module csp_divider (
   input  logic                    clock,
   input  logic                    reset,
   input  csp_pkg::div_req_type    div_req,
   output csp_pkg::div_rsp_type    div_rsp
);
   import csp_pkg::*;

   localparam int CNT_W = $clog2(QUO_W + 1);

   logic [DIM_W-1:0] rem_ff,  rem_in;
   logic [QUO_W-1:0] quo_ff,  quo_in;
   logic [DIM_W-1:0] div_ff,  div_in;
   logic [CNT_W-1:0] cnt_ff,  cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DIM_W:0]   trial;
   logic             fits;

   // trial subtract of the shifted partial remainder
   always_comb begin
      trial = {rem_ff, quo_ff[QUO_W-1]};
      fits  = trial >= {1'b0, div_ff};
   end

   // iteration control
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = DIM_W'(div_req.numerator[PROD_W-1:QUO_W]);
         quo_in  = div_req.numerator[QUO_W-1:0];
         div_in  = div_req.divisor;
         cnt_in  = CNT_W'(QUO_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = DIM_W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[DIM_W-1:0];
         end
         quo_in = {quo_ff[QUO_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ----- hdl/crop_scale_pixel_readout.sv -----
// ---------------------------------------------------------------------------
// crop_scale_pixel_readout
// Pixel store with nearest-neighbor crop and scale readout. Store beats
// write one 32-bit pixel; fetch beats map an output coordinate into the
// crop window and return the source pixel as an ARGB word.
// ---------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  opcode, index, four bytes, dest x/y
//  rsp      out        rsp_valid/rsp_stall  argb_word, range_error
//  csr      in         csr_write            csr_index, csr_data
//
//  A store beat gives no result. A fetch runs through two products, two
//  11-step divisions on one shared divider, the source index multiply
//  and the store read.
//  Reset returns the configuration registers to their defaults and the sequencer to idle; the store is not cleared.
//  A stalled result sits in the output register; the next beat is taken
//  meanwhile, and a fetch waits only at its end for that register to drain.
// ---------------------------------------------------------------------------
module crop_scale_pixel_readout (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_opcode,
   input  logic [csp_pkg::INDEX_W-1:0]        req_pixel_index,
   input  logic [csp_pkg::BYTE_W-1:0]         req_byte_zero,
   input  logic [csp_pkg::BYTE_W-1:0]         req_byte_one,
   input  logic [csp_pkg::BYTE_W-1:0]         req_byte_two,
   input  logic [csp_pkg::BYTE_W-1:0]         req_byte_three,
   input  logic [csp_pkg::COORD_W-1:0]        req_dest_x,
   input  logic [csp_pkg::COORD_W-1:0]        req_dest_y,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [csp_pkg::PIXEL_W-1:0]        rsp_argb_word,
   output logic                               rsp_range_error,

   input  logic                               csr_write,
   input  logic [csp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [csp_pkg::CSR_DATA_W-1:0]     csr_data
);
   import csp_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_XSTART,
      ST_XWAIT,
      ST_YSTART,
      ST_YWAIT,
      ST_ADDR,
      ST_CHECK,
      ST_READ,
      ST_RESULT
   } state_type;

   // configuration registers
   logic [DIM_W-1:0]   image_width_ff;
   logic               alpha_present_ff;
   logic [COORD_W-1:0] crop_left_ff;
   logic [COORD_W-1:0] crop_top_ff;
   logic [DIM_W-1:0]   crop_cols_ff;
   logic [DIM_W-1:0]   crop_rows_ff;
   logic [DIM_W-1:0]   dest_cols_ff;
   logic [DIM_W-1:0]   dest_rows_ff;

   // sequencer and working registers
   state_type          state_ff,  state_in;
   logic [COORD_W-1:0] dx_ff,     dx_in;
   logic [COORD_W-1:0] dy_ff,     dy_in;
   logic [PROD_W-1:0]  prod_x_ff, prod_x_in;
   logic [PROD_W-1:0]  prod_y_ff, prod_y_in;
   logic [QUO_W-1:0]   px_ff,     px_in;
   logic [SRC_W-1:0]   src_ff,    src_in;
   logic               sx_err_ff, sx_err_in;
   logic [PIXEL_W-1:0] word_ff,   word_in;
   logic               err_ff,    err_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0] rsp_word_ff,  rsp_word_in;
   logic               rsp_err_ff,   rsp_err_in;

   // store and divider hookup
   logic               accept;
   logic               out_free;
   logic               ram_wr_en;
   logic               ram_rd_en;
   logic [PIXEL_W-1:0] ram_rd_data;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   // address arithmetic
   logic [DIM_W-1:0]   sx;
   logic [DIM_W-1:0]   sy;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff   <= DIM_W'(1);
         alpha_present_ff <= 1'b1;
         crop_left_ff     <= '0;
         crop_top_ff      <= '0;
         crop_cols_ff     <= DIM_W'(1);
         crop_rows_ff     <= DIM_W'(1);
         dest_cols_ff     <= DIM_W'(1);
         dest_rows_ff     <= DIM_W'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:   image_width_ff   <= clamp_dim(csr_data);
            REG_ALPHA_PRESENT: alpha_present_ff <= csr_data[0];
            REG_CROP_LEFT:     crop_left_ff     <= csr_data[COORD_W-1:0];
            REG_CROP_TOP:      crop_top_ff      <= csr_data[COORD_W-1:0];
            REG_CROP_COLS:     crop_cols_ff     <= clamp_dim(csr_data);
            REG_CROP_ROWS:     crop_rows_ff     <= clamp_dim(csr_data);
            REG_DEST_COLS:     dest_cols_ff     <= clamp_dim(csr_data);
            REG_DEST_ROWS:     dest_rows_ff     <= clamp_dim(csr_data);
            default: ;
         endcase
      end
   end

   // store beats write straight into the pixel store
   assign ram_wr_en = accept && (req_opcode == OP_STORE) &&
                      (32'(req_pixel_index) < STORE_PIXELS);

   csp_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (STORE_PIXELS)
   ) u_pixel_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ADDR_W'(req_pixel_index)),
      .wr_data ({req_byte_zero, req_byte_one, req_byte_two, req_byte_three}),
      .rd_en   (ram_rd_en),
      .rd_addr (src_ff[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // shared coordinate divider
   always_comb begin
      div_req.start     = (state_ff == ST_XSTART) || (state_ff == ST_YSTART);
      div_req.numerator = (state_ff == ST_YSTART) ? prod_y_ff : prod_x_ff;
      div_req.divisor   = (state_ff == ST_YSTART) ? dest_rows_ff : dest_cols_ff;
   end

   csp_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // source column and row inside the image
   assign sx = DIM_W'(crop_left_ff) + px_ff;
   assign sy = DIM_W'(crop_top_ff) + div_rsp.quotient;

   assign ram_rd_en = (state_ff == ST_CHECK);

   // fetch sequencer
   always_comb begin
      state_in     = state_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      prod_x_in    = prod_x_ff;
      prod_y_in    = prod_y_ff;
      px_in        = px_ff;
      src_in       = src_ff;
      sx_err_in    = sx_err_ff;
      word_in      = word_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      rsp_err_in   = rsp_err_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_opcode == OP_FETCH)) begin
               dx_in    = req_dest_x;
               dy_in    = req_dest_y;
               state_in = ST_MUL;
            end
         end
         // output range check and the two scaling products
         ST_MUL: begin
            prod_x_in = PROD_W'(dx_ff * crop_cols_ff);
            prod_y_in = PROD_W'(dy_ff * crop_rows_ff);
            if (({1'b0, dx_ff} >= dest_cols_ff) || ({1'b0, dy_ff} >= dest_rows_ff)) begin
               word_in  = '0;
               err_in   = 1'b1;
               state_in = ST_RESULT;
            end else begin
               state_in = ST_XSTART;
            end
         end
         ST_XSTART: state_in = ST_XWAIT;
         ST_XWAIT: begin
            if (div_rsp.done) begin
               px_in    = div_rsp.quotient;
               state_in = ST_YSTART;
            end
         end
         ST_YSTART: state_in = ST_YWAIT;
         // quotient of the row division is used the cycle it lands
         ST_YWAIT: begin
            if (div_rsp.done) begin
               sx_err_in = (sx >= image_width_ff);
               src_in    = SRC_W'(sy * image_width_ff) + SRC_W'(sx);
               state_in  = ST_ADDR;
            end
         end
         ST_ADDR: begin
            if (sx_err_ff || (32'(src_ff) >= STORE_PIXELS)) begin
               word_in  = '0;
               err_in   = 1'b1;
               state_in = ST_RESULT;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: state_in = ST_READ;
         // alpha mode is applied on the way out of the store
         ST_READ: begin
            if (alpha_present_ff) begin
               word_in = ram_rd_data;
            end else begin
               word_in = {ALPHA_OPAQUE, ram_rd_data[PIXEL_W-1:BYTE_W]};
            end
            err_in   = 1'b0;
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = word_ff;
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      prod_x_ff   <= prod_x_in;
      prod_y_ff   <= prod_y_in;
      px_ff       <= px_in;
      src_ff      <= src_in;
      sx_err_ff   <= sx_err_in;
      word_ff     <= word_in;
      err_ff      <= err_in;
      rsp_word_ff <= rsp_word_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_argb_word   = rsp_word_ff;
   assign rsp_range_error = rsp_err_ff;

endmodule

// ----- sim/crop_scale_pixel_readout_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crop_scale_pixel_readout_test
// Self-checking bench for the crop and scale pixel readout. Pixel stores and
// coordinate fetches are driven through the req channel while a mirror of
// the pixel store and of the crop/scale registers predicts every readout.
// Directed tests cover register defaults, saturation and masking, the
// out-of-range cases, byte extremes and a long readout hold-off; random
// traffic then runs under several geometries and idle mixes.
// ---------------------------------------------------------------------------
module crop_scale_pixel_readout_test;
   import csp_pkg::*;

   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int SETTLE_CYCLES   = 48;
   localparam int HOLD_OFF_CYCLES = 500;
   localparam int GEOMETRY_SPAN   = 160;
   localparam int MAX_REPORTS     = 40;

   typedef struct packed {
      logic [PIXEL_W-1:0] argb_word;
      logic               range_error;
   } readout_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_opcode = OP_STORE;
   logic [INDEX_W-1:0]     req_pixel_index = '0;
   logic [BYTE_W-1:0]      req_byte_zero = '0;
   logic [BYTE_W-1:0]      req_byte_one = '0;
   logic [BYTE_W-1:0]      req_byte_two = '0;
   logic [BYTE_W-1:0]      req_byte_three = '0;
   logic [COORD_W-1:0]     req_dest_x = '0;
   logic [COORD_W-1:0]     req_dest_y = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b1;
   logic [PIXEL_W-1:0]     rsp_argb_word;
   logic                   rsp_range_error;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // shadow of the block's registers
   int unsigned shadow_image_width = 1;
   logic        shadow_alpha_present = 1'b1;
   int unsigned shadow_crop_left = 0;
   int unsigned shadow_crop_top = 0;
   int unsigned shadow_crop_cols = 1;
   int unsigned shadow_crop_rows = 1;
   int unsigned shadow_dest_cols = 1;
   int unsigned shadow_dest_rows = 1;

   // mirror of written store entries and readouts still to come
   logic [PIXEL_W-1:0] pixel_mirror [int unsigned];
   readout_type        expected_readouts [$];
   readout_type        head_readout;

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned hold_left = 0;
   int unsigned cycle_count = 0;
   int unsigned mismatches = 0;
   int unsigned stores_sent = 0;
   int unsigned fetches_sent = 0;
   int unsigned register_writes = 0;
   int unsigned geometry_changes = 0;
   int unsigned readouts_checked = 0;
   int unsigned range_errors_predicted = 0;

   crop_scale_pixel_readout i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_pixel_index (req_pixel_index),
      .req_byte_zero   (req_byte_zero),
      .req_byte_one    (req_byte_one),
      .req_byte_two    (req_byte_two),
      .req_byte_three  (req_byte_three),
      .req_dest_x      (req_dest_x),
      .req_dest_y      (req_dest_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_argb_word   (rsp_argb_word),
      .rsp_range_error (rsp_range_error),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // 100 MHz clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("crop_scale_pixel_readout regression: fail");
         $finish;
      end
   end

   // readout side back-pressure, long hold-off first
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else begin
         rsp_stall = ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
      end
   endtask

   // compare each readout beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_readouts.size() == 0) begin
            report_mismatch("readout with nothing outstanding", rsp_argb_word, '0);
         end else begin
            head_readout = expected_readouts.pop_front();
            readouts_checked++;
            if (rsp_argb_word !== head_readout.argb_word) begin
               report_mismatch("argb_word", rsp_argb_word, head_readout.argb_word);
            end
            if (rsp_range_error !== head_readout.range_error) begin
               report_mismatch("range_error", 32'(rsp_range_error),
                               32'(head_readout.range_error));
            end
         end
      end
   end

   function automatic int unsigned saturate_size(logic [CSR_DATA_W-1:0] value);
      return (value > MAX_DIMENSION) ? MAX_DIMENSION : int'(value);
   endfunction

   // nearest-neighbor map of an output coordinate to a linear store index
   function automatic bit map_to_source(logic [COORD_W-1:0] dx, logic [COORD_W-1:0] dy,
                                        output longint unsigned src);
      longint unsigned px, py, sx, sy;
      src = 0;
      if (dx >= shadow_dest_cols || dy >= shadow_dest_rows) return 1'b0;
      px = (longint'(dx) * shadow_crop_cols) / shadow_dest_cols;
      py = (longint'(dy) * shadow_crop_rows) / shadow_dest_rows;
      sx = shadow_crop_left + px;
      sy = shadow_crop_top + py;
      if (sx >= shadow_image_width) return 1'b0;
      src = sy * shadow_image_width + sx;
      return src < STORE_PIXELS;
   endfunction

   // expected readout of one accepted fetch
   function automatic readout_type predict_readout(logic [COORD_W-1:0] dx,
                                                   logic [COORD_W-1:0] dy);
      readout_type     r;
      longint unsigned src;
      logic [PIXEL_W-1:0] raw;
      r = '{argb_word: '0, range_error: 1'b1};
      if (map_to_source(dx, dy, src)) begin
         raw = pixel_mirror[src];
         r.range_error = 1'b0;
         r.argb_word = shadow_alpha_present ? raw : {ALPHA_OPAQUE, raw[31:8]};
      end
      return r;
   endfunction

   // one req beat; entered and left at a falling edge
   task automatic send_beat(logic op, logic [INDEX_W-1:0] index, logic [31:0] bytes,
                            logic [COORD_W-1:0] dx, logic [COORD_W-1:0] dy);
      readout_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_opcode = op;
      req_pixel_index = index;
      {req_byte_zero, req_byte_one, req_byte_two, req_byte_three} = bytes;
      req_dest_x = dx;
      req_dest_y = dy;
      do @(posedge clock); while (req_stall);
      if (op == OP_STORE) begin
         pixel_mirror[index] = bytes;
         stores_sent++;
      end else begin
         predicted = predict_readout(dx, dy);
         if (predicted.range_error) range_errors_predicted++;
         expected_readouts.push_back(predicted);
         fetches_sent++;
      end
      @(negedge clock);
   endtask

   task automatic store_pixel(logic [INDEX_W-1:0] index, logic [31:0] bytes);
      send_beat(OP_STORE, index, bytes, COORD_W'($urandom), COORD_W'($urandom));
   endtask

   // fetch, writing the source pixel first if it was never written
   task automatic fetch_pixel(logic [COORD_W-1:0] dx, logic [COORD_W-1:0] dy);
      longint unsigned src;
      if (map_to_source(dx, dy, src) && !pixel_mirror.exists(src)) begin
         store_pixel(INDEX_W'(src), $urandom);
      end
      send_beat(OP_FETCH, INDEX_W'($urandom), $urandom, dx, dy);
   endtask

   // wait until all readouts are back and the block has gone quiet
   task automatic quiesce();
      req_valid = 1'b0;
      while (expected_readouts.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      csr_write = 1'b1;
      csr_index = index;
      csr_data = value;
      case (index)
         REG_IMAGE_WIDTH:   shadow_image_width = saturate_size(value);
         REG_ALPHA_PRESENT: shadow_alpha_present = value[0];
         REG_CROP_LEFT:     shadow_crop_left = value[COORD_W-1:0];
         REG_CROP_TOP:      shadow_crop_top = value[COORD_W-1:0];
         REG_CROP_COLS:     shadow_crop_cols = saturate_size(value);
         REG_CROP_ROWS:     shadow_crop_rows = saturate_size(value);
         REG_DEST_COLS:     shadow_dest_cols = saturate_size(value);
         REG_DEST_ROWS:     shadow_dest_rows = saturate_size(value);
         default: ;
      endcase
      register_writes++;
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   task automatic set_geometry(int unsigned width, int unsigned left, int unsigned top,
                               int unsigned ccols, int unsigned crows,
                               int unsigned dcols, int unsigned drows, bit alpha);
      quiesce();
      write_reg(REG_IMAGE_WIDTH, CSR_DATA_W'(width));
      write_reg(REG_CROP_LEFT, CSR_DATA_W'(left));
      write_reg(REG_CROP_TOP, CSR_DATA_W'(top));
      write_reg(REG_CROP_COLS, CSR_DATA_W'(ccols));
      write_reg(REG_CROP_ROWS, CSR_DATA_W'(crows));
      write_reg(REG_DEST_COLS, CSR_DATA_W'(dcols));
      write_reg(REG_DEST_ROWS, CSR_DATA_W'(drows));
      write_reg(REG_ALPHA_PRESENT, CSR_DATA_W'(alpha));
   endtask

   // size write: mostly small, sometimes the extremes or an oversized value
   function automatic logic [CSR_DATA_W-1:0] pick_size_value();
      case ($urandom_range(7))
         0: return CSR_DATA_W'(MAX_DIMENSION);
         1: return CSR_DATA_W'(1);
         2: return CSR_DATA_W'($urandom_range(2047, MAX_DIMENSION + 1));
         default: return CSR_DATA_W'($urandom_range(40, 2));
      endcase
   endfunction

   task automatic shuffle_geometry();
      int unsigned rows_in_store;
      quiesce();
      write_reg(REG_IMAGE_WIDTH, pick_size_value());
      if ($urandom_range(9) != 0) begin
         write_reg(REG_CROP_LEFT, {1'($urandom),
                                   COORD_W'($urandom_range(shadow_image_width - 1))});
      end else begin
         write_reg(REG_CROP_LEFT, CSR_DATA_W'($urandom));
      end
      rows_in_store = STORE_PIXELS / shadow_image_width;
      if (rows_in_store > MAX_DIMENSION) rows_in_store = MAX_DIMENSION;
      if ($urandom_range(9) != 0) begin
         write_reg(REG_CROP_TOP, {1'($urandom), COORD_W'($urandom_range(rows_in_store - 1))});
      end else begin
         write_reg(REG_CROP_TOP, CSR_DATA_W'($urandom));
      end
      write_reg(REG_CROP_COLS, pick_size_value());
      write_reg(REG_CROP_ROWS, pick_size_value());
      write_reg(REG_DEST_COLS, pick_size_value());
      write_reg(REG_DEST_ROWS, pick_size_value());
      write_reg(REG_ALPHA_PRESENT, CSR_DATA_W'($urandom));
      // unused indexes must leave everything alone
      write_reg(CSR_INDEX_W'($urandom_range(15, 8)), CSR_DATA_W'($urandom));
      geometry_changes++;
   endtask

   // registers at their reset values: 1x1 image, 1:1
   task automatic test_reset_defaults();
      store_pixel('0, 32'hA1B2_C3D4);
      fetch_pixel(0, 0);
      fetch_pixel(1, 0);
      fetch_pixel(0, 1);
      fetch_pixel(10'h3FF, 10'h3FF);
   endtask

   // saturation of sizes, masking of crop offsets and alpha, unused indexes, zero sizes
   task automatic test_register_extremes();
      quiesce();
      write_reg(REG_IMAGE_WIDTH, 11'h7FF);
      write_reg(REG_CROP_COLS, 11'h7FF);
      write_reg(REG_CROP_ROWS, 11'd1500);
      write_reg(REG_DEST_COLS, 11'h7FF);
      write_reg(REG_DEST_ROWS, 11'd1024);
      write_reg(REG_CROP_LEFT, 11'h7FF);
      write_reg(REG_CROP_TOP, 11'h400);
      write_reg(REG_ALPHA_PRESENT, 11'h7FE);
      // source column runs past the image
      fetch_pixel(10'h3FF, 0);
      fetch_pixel(0, 0);
      quiesce();
      write_reg(4'd15, 11'd0);
      write_reg(4'd8, 11'd0);
      fetch_pixel(0, 0);
      // zero image width
      quiesce();
      write_reg(REG_IMAGE_WIDTH, 11'd0);
      fetch_pixel(0, 0);
      // zero output width, then a zero crop width collapsing every column
      set_geometry(8, 2, 0, 0, 1024, 0, 1024, 1'b1);
      fetch_pixel(0, 0);
      quiesce();
      write_reg(REG_DEST_COLS, 11'd4);
      fetch_pixel(3, 5);
   endtask

   // last store entry and linear indexes beyond the store
   task automatic test_source_limits();
      set_geometry(1024, 0, 63, 1024, 2, 1024, 2, 1'b1);
      fetch_pixel(10'h3FF, 0);
      fetch_pixel(0, 1);
      quiesce();
      write_reg(REG_CROP_TOP, 11'd1023);
      fetch_pixel(0, 0);
   endtask

   // all-zero and all-one pixels in both byte layouts
   task automatic test_byte_extremes();
      set_geometry(2, 0, 0, 2, 1, 2, 1, 1'b1);
      store_pixel('0, 32'h0000_0000);
      store_pixel(16'd1, 32'hFFFF_FFFF);
      fetch_pixel(0, 0);
      fetch_pixel(1, 0);
      quiesce();
      write_reg(REG_ALPHA_PRESENT, 11'd0);
      fetch_pixel(0, 0);
      fetch_pixel(1, 0);
   endtask

   // readouts held off for a long stretch so the block backs up its input
   task automatic test_output_hold_off();
      set_geometry(8, 0, 0, 8, 8, 8, 8, 1'b1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      @(posedge clock);
      hold_left = HOLD_OFF_CYCLES;
      @(negedge clock);
      repeat (24) fetch_pixel(COORD_W'($urandom_range(7)), COORD_W'($urandom_range(7)));
   endtask

   // mostly write-then-read traffic inside the crop window, plus noise
   task automatic test_random_traffic(int beats, int unsigned send_pct, int unsigned recv_pct);
      longint unsigned src;
      logic [COORD_W-1:0] dx, dy;
      int unsigned pick;
      for (int i = 0; i < beats; i++) begin
         if (i % GEOMETRY_SPAN == 0) begin
            shuffle_geometry();
            send_idle_pct = send_pct;
            recv_idle_pct = recv_pct;
         end
         dx = (shadow_dest_cols != 0) ? COORD_W'($urandom_range(shadow_dest_cols - 1))
                                      : COORD_W'($urandom);
         dy = (shadow_dest_rows != 0) ? COORD_W'($urandom_range(shadow_dest_rows - 1))
                                      : COORD_W'($urandom);
         pick = $urandom_range(99);
         if (pick < 25) begin
            if (map_to_source(dx, dy, src)) store_pixel(INDEX_W'(src), $urandom);
            else store_pixel(INDEX_W'($urandom), $urandom);
         end else if (pick < 35) begin
            store_pixel(INDEX_W'($urandom), $urandom);
         end else if (pick < 45) begin
            fetch_pixel(COORD_W'($urandom), COORD_W'($urandom));
         end else begin
            fetch_pixel(dx, dy);
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      send_idle_pct = 16;
      recv_idle_pct = 66;
      test_reset_defaults();
      test_register_extremes();
      test_source_limits();
      test_byte_extremes();
      test_output_hold_off();
      test_random_traffic(240, 16, 66);
      test_random_traffic(240, 66, 16);
      test_random_traffic(230, 0, 0);
      // drain and let the block settle
      req_valid = 1'b0;
      while (expected_readouts.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("ran %0d store beats and %0d fetch beats over %0d random geometries",
               stores_sent, fetches_sent, geometry_changes);
      $display("checked %0d readouts (%0d out of range) after %0d register writes",
               readouts_checked, range_errors_predicted, register_writes);
      if (mismatches == 0) begin
         $display("crop_scale_pixel_readout regression: pass");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("crop_scale_pixel_readout regression: fail");
      end
      $finish;
   end

endmodule
